>>> hw/rtl/mbps_pkg.sv
// shared constants and register codes of the masked byte pattern scanner
package mbps_pkg;

  localparam int DEF_MAX_PATTERN_BYTES = 16;
  localparam int DEF_ADDRESS_BITS      = 48;

  // pattern bytes that the two pattern registers can hold
  localparam int REG_PATTERN_BYTES = 16;

  localparam int LEN_W      = 5;
  localparam int CFG_ADDR_W = 6;
  localparam int CFG_DATA_W = 64;
  localparam int REG_IDX_W  = 3;
  localparam int ORD_W      = 32;
  localparam int MASK_W     = 16;

  localparam logic [ORD_W-1:0] COUNT_TOP = 32'hFFFF_FFFF;
  localparam logic [7:0]       BYTE_ONES = 8'hFF;

  // result words held between the compare stage and the output
  localparam int QUEUE_DEPTH = 8;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PATTERN_LOW  = 3'd0,
    REG_PATTERN_HIGH = 3'd1,
    REG_CARE_MASK    = 3'd2,
    REG_PATTERN_LEN  = 3'd3,
    REG_WANTED_OCC   = 3'd4
  } mbps_reg_t;

endpackage

>>> hw/rtl/mbps_if.sv
// valid/ready channels for scanned bytes and scan results
interface mbps_in_if #(
  parameter int ADDRESS_BITS = mbps_pkg::DEF_ADDRESS_BITS
);
  logic                    valid;
  logic                    ready;
  logic [7:0]              data_byte;
  logic [ADDRESS_BITS-1:0] byte_address;
  logic                    region_first;
  logic                    scan_last;

  modport source (
    output valid, data_byte, byte_address, region_first, scan_last,
    input  ready
  );
  modport sink (
    input  valid, data_byte, byte_address, region_first, scan_last,
    output ready
  );
endinterface

interface mbps_out_if #(
  parameter int ADDRESS_BITS = mbps_pkg::DEF_ADDRESS_BITS
);
  logic                    valid;
  logic                    ready;
  logic [ADDRESS_BITS-1:0] match_address;
  logic [31:0]             match_ordinal;
  logic                    is_wanted;
  logic                    is_summary;
  logic                    wanted_found;

  modport source (
    output valid, match_address, match_ordinal, is_wanted, is_summary, wanted_found,
    input  ready
  );
  modport sink (
    input  valid, match_address, match_ordinal, is_wanted, is_summary, wanted_found,
    output ready
  );
endinterface

>>> hw/rtl/masked_byte_pattern_scanner_unit.sv
// masked byte pattern scanner: window compare, match counting and result queue
// path: an accepted byte is registered in the input register, compared there, and its result words
//   are written into the result queue, whose head word is offered at the output
// throughput: one byte per cycle while ready is high; a byte that gives a match and a summary puts two words
//   in the queue; ready drops once queued words, plus two for a byte in the compare stage, pass six
// reset: synchronous, clears registers, counters, window fill and the queue, ready held low
module masked_byte_pattern_scanner_unit #(
  parameter int MAX_PATTERN_BYTES = mbps_pkg::DEF_MAX_PATTERN_BYTES,
  parameter int ADDRESS_BITS      = mbps_pkg::DEF_ADDRESS_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  mbps_in_if.sink                           scan_in,
  mbps_out_if.source                        scan_out,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mbps_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [mbps_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import mbps_pkg::*;

  localparam int LEN_CAP = (MAX_PATTERN_BYTES < REG_PATTERN_BYTES) ?
                           MAX_PATTERN_BYTES : REG_PATTERN_BYTES;
  localparam int FILL_W  = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);

  // configuration registers
  logic [63:0]       pattern_bytes_low;
  logic [63:0]       pattern_bytes_high;
  logic [MASK_W-1:0] byte_care_mask;
  logic [LEN_W-1:0]  pattern_length;
  logic [ORD_W-1:0]  wanted_occurrence;

  logic      cfg_write;
  mbps_reg_t cfg_reg;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_reg   = mbps_reg_t'(paddr[CFG_ADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes_low  <= '0;
      pattern_bytes_high <= '0;
      byte_care_mask     <= '0;
      pattern_length     <= LEN_W'(1);
      wanted_occurrence  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_reg)
        REG_PATTERN_LOW:  pattern_bytes_low  <= pwdata;
        REG_PATTERN_HIGH: pattern_bytes_high <= pwdata;
        REG_CARE_MASK:    byte_care_mask     <= pwdata[MASK_W-1:0];
        REG_PATTERN_LEN:  pattern_length     <= pwdata[LEN_W-1:0];
        REG_WANTED_OCC:   wanted_occurrence  <= pwdata[ORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg)
      REG_PATTERN_LOW:  prdata = pattern_bytes_low;
      REG_PATTERN_HIGH: prdata = pattern_bytes_high;
      REG_CARE_MASK:    prdata = CFG_DATA_W'(byte_care_mask);
      REG_PATTERN_LEN:  prdata = CFG_DATA_W'(pattern_length);
      REG_WANTED_OCC:   prdata = CFG_DATA_W'(wanted_occurrence);
      default:          prdata = '0;
    endcase
  end

  // input register
  logic                    s1_valid;
  logic [7:0]              s1_data;
  logic [ADDRESS_BITS-1:0] s1_addr;
  logic                    s1_first;
  logic                    s1_last;
  logic                    in_accept;

  assign in_accept = scan_in.valid && scan_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_data  <= scan_in.data_byte;
      s1_addr  <= scan_in.byte_address;
      s1_first <= scan_in.region_first;
      s1_last  <= scan_in.scan_last;
    end
  end

  // scan state
  logic [7:0]              byte_window [MAX_PATTERN_BYTES];
  logic [FILL_W-1:0]       window_fill;
  logic [ORD_W-1:0]        match_count;
  logic [ADDRESS_BITS-1:0] selected_address;
  logic                    selected_seen;

  logic [7:0]              window_next [MAX_PATTERN_BYTES];
  logic [FILL_W-1:0]       fill_start;
  logic [FILL_W-1:0]       fill_shifted;
  logic [LEN_W-1:0]        len_eff;
  logic                    window_ok;
  logic                    hit;
  logic                    wanted;
  logic [ADDRESS_BITS-1:0] start_address;
  logic [ORD_W-1:0]        count_after;
  logic [ADDRESS_BITS-1:0] selected_after;
  logic                    seen_after;

  always_comb begin
    if (pattern_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(pattern_length) > LEN_CAP) begin
      len_eff = LEN_W'(LEN_CAP);
    end else begin
      len_eff = pattern_length;
    end
  end

  always_comb begin
    window_next[0] = s1_data;
    for (int i = 1; i < MAX_PATTERN_BYTES; i++) begin
      window_next[i] = byte_window[i-1];
    end
  end

  assign fill_start   = s1_first ? '0 : window_fill;
  assign fill_shifted = (32'(fill_start) < MAX_PATTERN_BYTES) ?
                        fill_start + FILL_W'(1) : fill_start;

  // pattern byte j lines up with the window entry len - 1 - j
  always_comb begin
    logic [127:0] pattern_all;
    logic [7:0]   got;
    logic [7:0]   care;
    pattern_all = {pattern_bytes_high, pattern_bytes_low};
    window_ok   = 1'b1;
    for (int j = 0; j < LEN_CAP; j++) begin
      got = '0;
      for (int k = 0; k < LEN_CAP; k++) begin
        if (32'(len_eff) == k + j + 1) begin
          got = window_next[k];
        end
      end
      care = byte_care_mask[j] ? BYTE_ONES : 8'h00;
      if ((32'(len_eff) > j) && ((got & care) != (pattern_all[8*j +: 8] & care))) begin
        window_ok = 1'b0;
      end
    end
  end

  assign hit           = s1_valid && (32'(fill_shifted) >= 32'(len_eff)) && window_ok;
  assign wanted        = hit && !selected_seen && (match_count == wanted_occurrence);
  assign start_address = s1_addr - ADDRESS_BITS'(len_eff - LEN_W'(1));
  assign count_after   = (hit && (match_count != COUNT_TOP)) ?
                         match_count + ORD_W'(1) : match_count;
  assign selected_after = wanted ? start_address : selected_address;
  assign seen_after     = selected_seen || wanted;

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      byte_window <= window_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_fill      <= '0;
      match_count      <= '0;
      selected_address <= '0;
      selected_seen    <= 1'b0;
    end else if (s1_valid) begin
      if (s1_last) begin
        window_fill      <= '0;
        match_count      <= '0;
        selected_address <= '0;
        selected_seen    <= 1'b0;
      end else begin
        window_fill      <= fill_shifted;
        match_count      <= count_after;
        selected_address <= selected_after;
        selected_seen    <= seen_after;
      end
    end
  end

  // result words: a match first, then the summary when the scan ends
  logic [ADDRESS_BITS-1:0] sum_addr;
  logic [ADDRESS_BITS-1:0] word_a_addr;
  logic [ORD_W-1:0]        word_a_ord;
  logic [2:0]              word_a_flags;
  logic [2:0]              sum_flags;
  logic [1:0]              push_n;

  assign sum_addr     = seen_after ? selected_after : '0;
  assign sum_flags    = {1'b0, 1'b1, seen_after};
  assign word_a_addr  = hit ? start_address : sum_addr;
  assign word_a_ord   = hit ? match_count : count_after;
  assign word_a_flags = hit ? {wanted, 1'b0, 1'b0} : sum_flags;
  assign push_n       = 2'(hit) + 2'(s1_valid && s1_last);

  logic [ADDRESS_BITS-1:0] q_addr  [QUEUE_DEPTH];
  logic [ORD_W-1:0]        q_ord   [QUEUE_DEPTH];
  logic [2:0]              q_flags [QUEUE_DEPTH];
  logic [PTR_W-1:0]        wr_ptr;
  logic [PTR_W-1:0]        rd_ptr;
  logic [CNT_W-1:0]        q_count;
  logic                    pop;

  assign pop = scan_out.valid && scan_out.ready;

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q_addr[wr_ptr]  <= word_a_addr;
      q_ord[wr_ptr]   <= word_a_ord;
      q_flags[wr_ptr] <= word_a_flags;
    end
    if (push_n == 2'd2) begin
      q_addr[wr_ptr + PTR_W'(1)]  <= sum_addr;
      q_ord[wr_ptr + PTR_W'(1)]   <= count_after;
      q_flags[wr_ptr + PTR_W'(1)] <= sum_flags;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      wr_ptr  <= wr_ptr + PTR_W'(push_n);
      rd_ptr  <= rd_ptr + PTR_W'(pop);
      q_count <= q_count + CNT_W'(push_n) - CNT_W'(pop);
    end
  end

  // room for two words from the byte in the compare stage and two from a new one
  assign scan_in.ready = !rst && ((32'(q_count) + (s1_valid ? 2 : 0)) <= QUEUE_DEPTH - 2);

  assign scan_out.valid         = q_count != '0;
  assign scan_out.match_address = q_addr[rd_ptr];
  assign scan_out.match_ordinal = q_ord[rd_ptr];
  assign scan_out.is_wanted     = q_flags[rd_ptr][2];
  assign scan_out.is_summary    = q_flags[rd_ptr][1];
  assign scan_out.wanted_found  = q_flags[rd_ptr][0];

  a_scan_end_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_last) |=> (match_count == '0 && !selected_seen && window_fill == '0))
    else $error("scan state not cleared after summary");

  a_selection_from_match: assert property (@(posedge clk) disable iff (rst)
    $rose(selected_seen) |-> $past(hit))
    else $error("wanted occurrence selected without a match");

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (32'(q_count) + 32'(push_n)) <= QUEUE_DEPTH + (pop ? 1 : 0))
    else $error("result queue overflow");

  a_pop_only_drain: assert property (@(posedge clk) disable iff (rst)
    (pop && push_n == 2'd0) |=> (q_count == $past(q_count) - CNT_W'(1)))
    else $error("result queue count lost a word");

endmodule

>>> verif/tb_masked_byte_pattern_scanner_unit.sv
// testbench of the masked byte pattern scanner: predicted match and summary words checked in order
`timescale 1ns / 100ps

module tb_masked_byte_pattern_scanner_unit;
  import mbps_pkg::*;

  localparam int MAX_BYTES = DEF_MAX_PATTERN_BYTES;
  localparam int ADDR_W    = DEF_ADDRESS_BITS;
  localparam int LEN_CAP   = (MAX_BYTES < REG_PATTERN_BYTES) ? MAX_BYTES : REG_PATTERN_BYTES;
  localparam int REG_STRIDE = 8;
  // indexes with no register behind them
  localparam int SPARE_REG_FIRST = 5;
  localparam int SPARE_REG_LAST  = 7;

  localparam int RANDOM_PHASES    = 12;
  localparam int PHASE_BYTES      = 161;
  localparam int HOLD_PHASE       = 3;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES    = 6;
  localparam int MAX_REPORTS      = 40;
  localparam int RUN_LIMIT_NS     = 2_000_000;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic [ORD_W-1:0]  ordinal;
    logic              wanted;
    logic              summary;
    logic              found;
  } scan_result_t;

  typedef enum {SINK_OPEN, SINK_LIGHT, SINK_HEAVY, SINK_PERIODIC} sink_style_t;

  class scan_match_model;
    logic [63:0]         pat_low;
    logic [63:0]         pat_high;
    logic [MASK_W-1:0]   care_mask;
    logic [LEN_W-1:0]    pat_len;
    logic [ORD_W-1:0]    wanted_occ;
    logic [7:0]          window [MAX_BYTES];
    int unsigned         fill;
    logic [ORD_W-1:0]    match_cnt;
    logic [ADDR_W-1:0]   sel_addr;
    bit                  sel_seen;
    scan_result_t        due_results [$];
    int unsigned         mismatches;

    function new();
      pat_low    = '0;
      pat_high   = '0;
      care_mask  = '0;
      pat_len    = LEN_W'(1);
      wanted_occ = '0;
      foreach (window[i]) window[i] = '0;
      fill       = 0;
      match_cnt  = '0;
      sel_addr   = '0;
      sel_seen   = 1'b0;
      mismatches = 0;
    endfunction

    function void write_reg(int idx, logic [63:0] value);
      case (idx)
        REG_PATTERN_LOW:  pat_low = value;
        REG_PATTERN_HIGH: pat_high = value;
        REG_CARE_MASK:    care_mask = value[MASK_W-1:0];
        REG_PATTERN_LEN:  pat_len = value[LEN_W-1:0];
        REG_WANTED_OCC:   wanted_occ = value[ORD_W-1:0];
        default: ;
      endcase
    endfunction

    // zero counts as one, anything past what the registers hold is clipped
    function int unsigned active_length();
      if (pat_len == 0) return 1;
      if (pat_len > LEN_CAP) return LEN_CAP;
      return pat_len;
    endfunction

    function void note_byte(logic [7:0] data, logic [ADDR_W-1:0] addr, bit first, bit last);
      int unsigned  len;
      int unsigned  i;
      bit           hit;
      logic [127:0] pat;
      scan_result_t r;
      len = active_length();
      pat = {pat_high, pat_low};
      if (first) fill = 0;
      for (i = MAX_BYTES - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = data;
      if (fill < MAX_BYTES) fill++;
      if (fill >= len) begin
        hit = 1'b1;
        // window[0] is the newest byte, pattern byte 0 is the oldest of the match
        for (i = 0; i < len; i++)
          if (care_mask[i] && window[len-1-i] != pat[8*i +: 8]) hit = 1'b0;
        if (hit) begin
          r.addr    = addr - ADDR_W'(len - 1);
          r.ordinal = match_cnt;
          r.wanted  = !sel_seen && match_cnt == wanted_occ;
          r.summary = 1'b0;
          r.found   = 1'b0;
          if (r.wanted) begin
            sel_seen = 1'b1;
            sel_addr = r.addr;
          end
          due_results.insert(due_results.size(), r);
          if (match_cnt != COUNT_TOP) match_cnt++;
        end
      end
      if (last) begin
        r.addr    = sel_seen ? sel_addr : '0;
        r.ordinal = match_cnt;
        r.wanted  = 1'b0;
        r.summary = 1'b1;
        r.found   = sel_seen;
        due_results.insert(due_results.size(), r);
        fill      = 0;
        match_cnt = '0;
        sel_addr  = '0;
        sel_seen  = 1'b0;
      end
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("scan mismatch %0d: %s", mismatches, what);
    endtask

    task check_result(scan_result_t got);
      scan_result_t want;
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("word with none expected: address %h ordinal %0d summary %b",
                                  got.addr, got.ordinal, got.summary));
        return;
      end
      want = due_results.pop_front();
      if (got.addr !== want.addr)
        report_mismatch($sformatf("match_address %h, expected %h", got.addr, want.addr));
      if (got.ordinal !== want.ordinal)
        report_mismatch($sformatf("match_ordinal %0d, expected %0d", got.ordinal, want.ordinal));
      if (got.wanted !== want.wanted)
        report_mismatch($sformatf("is_wanted %b, expected %b", got.wanted, want.wanted));
      if (got.summary !== want.summary)
        report_mismatch($sformatf("is_summary %b, expected %b", got.summary, want.summary));
      if (got.found !== want.found)
        report_mismatch($sformatf("wanted_found %b, expected %b", got.found, want.found));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  mbps_in_if  #(.ADDRESS_BITS(ADDR_W)) scan_in_ch ();
  mbps_out_if #(.ADDRESS_BITS(ADDR_W)) scan_out_ch ();

  scan_match_model scan_model = new();

  bit                long_hold_req = 1'b0;
  bit                gap_free = 1'b0;
  int unsigned       burst_left = 0;

  masked_byte_pattern_scanner_unit #(
    .MAX_PATTERN_BYTES(MAX_BYTES),
    .ADDRESS_BITS(ADDR_W)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .scan_in(scan_in_ch),
    .scan_out(scan_out_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin : observe
    scan_result_t got;
    if (!rst) begin
      if (scan_in_ch.valid && scan_in_ch.ready)
        scan_model.note_byte(scan_in_ch.data_byte, scan_in_ch.byte_address,
                             scan_in_ch.region_first, scan_in_ch.scan_last);
      if (scan_out_ch.valid && scan_out_ch.ready) begin
        got.addr    = scan_out_ch.match_address;
        got.ordinal = scan_out_ch.match_ordinal;
        got.wanted  = scan_out_ch.is_wanted;
        got.summary = scan_out_ch.is_summary;
        got.found   = scan_out_ch.wanted_found;
        scan_model.check_result(got);
      end
    end
  end

  // result side: stall styles change at random, plus one long hold on request
  initial begin : result_sink
    sink_style_t style;
    int unsigned style_left;
    int unsigned tick;
    style_left = 0;
    tick = 0;
    scan_out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        scan_out_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end
      if (style_left == 0) begin
        style = sink_style_t'($urandom_range(0, 3));
        style_left = $urandom_range(16, 160);
      end
      style_left--;
      tick++;
      case (style)
        SINK_OPEN:  scan_out_ch.ready <= 1'b1;
        SINK_LIGHT: scan_out_ch.ready <= ($urandom_range(0, 3) != 0);
        SINK_HEAVY: scan_out_ch.ready <= ($urandom_range(0, 9) < 3);
        default:    scan_out_ch.ready <= ((tick % 8) >= 3);
      endcase
      @(posedge clk);
    end
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("[masked_byte_pattern_scanner_unit] ERROR");
    $finish;
  end

  function automatic logic [ADDR_W-1:0] pick_base();
    case ($urandom_range(0, 4))
      // region runs over the top of the address space
      0: return {ADDR_W{1'b1}} - ADDR_W'($urandom_range(0, 40));
      1: return ADDR_W'($urandom_range(0, 40));
      default: return ADDR_W'({$urandom, $urandom});
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] d, input logic [ADDR_W-1:0] a,
                           input bit f, input bit l);
    scan_in_ch.valid        <= 1'b1;
    scan_in_ch.data_byte    <= d;
    scan_in_ch.byte_address <= a;
    scan_in_ch.region_first <= f;
    scan_in_ch.scan_last    <= l;
    do @(posedge clk); while (!scan_in_ch.ready);
  endtask

  task automatic paced_send(input logic [7:0] d, input logic [ADDR_W-1:0] a,
                            input bit f, input bit l);
    if (burst_left == 0) begin
      if (!gap_free) begin
        scan_in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 32);
    end
    burst_left--;
    send_byte(d, a, f, l);
  endtask

  // the extra edge lets the monitor log the last accepted byte first
  task automatic drain_results();
    scan_in_ch.valid <= 1'b0;
    @(posedge clk);
    while (scan_model.due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input int idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(idx * REG_STRIDE);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    scan_model.write_reg(idx, value);
  endtask

  initial begin : stimulus
    int unsigned       phase, k, j, n, len;
    int unsigned       region_left, scan_regions_left;
    logic [ADDR_W-1:0] next_addr;
    logic [7:0]        plant_q [$];
    logic [63:0]       v, junk;
    logic [MASK_W-1:0] m;
    logic [LEN_W-1:0]  plen;
    logic [ORD_W-1:0]  w;
    logic [127:0]      pat;
    logic [7:0]        d;
    bit                f, l;

    rst                     <= 1'b1;
    scan_in_ch.valid        <= 1'b0;
    scan_in_ch.data_byte    <= '0;
    scan_in_ch.byte_address <= '0;
    scan_in_ch.region_first <= 1'b0;
    scan_in_ch.scan_last    <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: one wildcard byte, so every byte matches
    send_byte(8'h00, 48'h0, 1'b1, 1'b0);
    send_byte(8'hFF, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b0);
    send_byte(8'h5A, 48'h0000_0000_1234, 1'b0, 1'b1);
    send_byte(8'hA5, 48'h5, 1'b1, 1'b1);
    drain_results();

    // full sixteen byte pattern over an address wrap, length written too large
    reg_write(REG_PATTERN_LOW, 64'h1716_1514_1312_1110);
    reg_write(REG_PATTERN_HIGH, 64'h1F1E_1D1C_1B1A_1918);
    reg_write(REG_CARE_MASK, 64'h0000_0000_0000_FFFF);
    reg_write(REG_PATTERN_LEN, 64'd31);
    reg_write(REG_WANTED_OCC, 64'd1);
    reg_write(SPARE_REG_FIRST, 64'hDEAD_BEEF_0000_0003);
    for (k = 0; k < 16; k++)
      send_byte(8'h10 + 8'(k), 48'hFFFF_FFFF_FFF8 + ADDR_W'(k), k == 0, k == 15);
    drain_results();

    // length zero acts as one, mask bit zero clear and high mask bits ignored
    reg_write(REG_PATTERN_LEN, 64'd0);
    reg_write(REG_CARE_MASK, 64'hFFFF_FFFF_FFFF_FFFE);
    reg_write(REG_WANTED_OCC, 64'd2);
    send_byte(8'h3C, 48'd100, 1'b1, 1'b0);
    send_byte(8'hC3, 48'd101, 1'b0, 1'b0);
    drain_results();
    // settings change in the middle of a region
    reg_write(REG_CARE_MASK, 64'h0000_0000_0000_FFFF);
    send_byte(8'h10, 48'd102, 1'b0, 1'b0);
    send_byte(8'h11, 48'd103, 1'b0, 1'b1);

    region_left = 0;
    scan_regions_left = 0;
    next_addr = '0;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_results();
      junk = {$urandom, $urandom};
      case ($urandom_range(0, 5))
        0: v = '0;
        1: v = {64{1'b1}};
        default: v = {$urandom, $urandom};
      endcase
      reg_write(REG_PATTERN_LOW, v);
      v = ($urandom_range(0, 5) == 0) ? {64{1'b1}} : {$urandom, $urandom};
      reg_write(REG_PATTERN_HIGH, v);
      case ($urandom_range(0, 4))
        0: m = {MASK_W{1'b1}};
        1: m = '0;
        default: m = MASK_W'($urandom);
      endcase
      case ($urandom_range(0, 9))
        0: plen = LEN_W'(1);
        1: plen = LEN_W'(LEN_CAP);
        2: plen = '0;
        3: plen = LEN_W'($urandom_range(17, 31));
        default: plen = LEN_W'($urandom_range(2, 15));
      endcase
      // every byte a match while the result side holds off, so the block backs up
      if (phase == HOLD_PHASE) begin
        m = '0;
        plen = LEN_W'(1);
      end
      reg_write(REG_CARE_MASK, {junk[63:MASK_W], m});
      reg_write(REG_PATTERN_LEN, {junk[63:LEN_W], plen});
      case ($urandom_range(0, 9))
        8: w = $urandom;
        9: w = COUNT_TOP;
        default: w = $urandom_range(0, 3);
      endcase
      reg_write(REG_WANTED_OCC, {junk[63:ORD_W], w});
      if ($urandom_range(0, 2) == 0)
        reg_write($urandom_range(SPARE_REG_FIRST, SPARE_REG_LAST), junk);

      len = scan_model.active_length();
      pat = {scan_model.pat_high, scan_model.pat_low};
      plant_q.delete();
      gap_free = (phase == HOLD_PHASE) || ($urandom_range(0, 3) == 0);
      burst_left = 0;
      if (phase == HOLD_PHASE) long_hold_req = 1'b1;

      for (k = 0; k < PHASE_BYTES; k++) begin
        f = 1'b0;
        if (region_left == 0) begin
          f = 1'b1;
          if (scan_regions_left == 0) scan_regions_left = $urandom_range(1, 4);
          scan_regions_left--;
          case ($urandom_range(0, 4))
            0: region_left = $urandom_range(1, 4);
            1: region_left = $urandom_range(30, 80);
            default: region_left = $urandom_range(len, len + 30);
          endcase
          next_addr = pick_base();
        end
        if (plant_q.size() == 0) begin
          if ($urandom_range(0, 9) < 4) begin
            // a full copy, random where the mask leaves a wildcard
            for (j = 0; j < len; j++)
              plant_q.insert(plant_q.size(),
                             scan_model.care_mask[j] ? pat[8*j +: 8] : 8'($urandom));
          end else begin
            n = $urandom_range(1, 4);
            for (j = 0; j < n; j++)
              plant_q.insert(plant_q.size(), $urandom_range(0, 1) ?
                             pat[8*$urandom_range(0, len - 1) +: 8] : 8'($urandom));
          end
        end
        d = plant_q.pop_front();
        l = (region_left == 1) && (scan_regions_left == 0);
        // stray region and scan marks, and address jumps inside a region
        if ($urandom_range(0, 99) < 3) f = 1'b1;
        if ($urandom_range(0, 99) < 2) l = 1'b1;
        if ($urandom_range(0, 99) < 2) next_addr = pick_base();
        paced_send(d, next_addr, f, l);
        next_addr++;
        region_left--;
      end
    end

    drain_results();
    if (scan_model.due_results.size() != 0)
      scan_model.report_mismatch($sformatf("%0d expected words never came",
                                           scan_model.due_results.size()));
    if (scan_model.mismatches == 0)
      $display("[masked_byte_pattern_scanner_unit] OK");
    else
      $display("[masked_byte_pattern_scanner_unit] ERROR");
    $finish;
  end

endmodule
